[hw/rtl/block_cache_fifo_writeback_unit_macros.svh]
// assertion macros shared by the block cache writeback unit
`ifndef BLOCK_CACHE_FIFO_WRITEBACK_UNIT_MACROS_SVH
`define BLOCK_CACHE_FIFO_WRITEBACK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BCFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BCFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define BCFW_ASSERT(lbl, prop, msg)
`define BCFW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/bcfw_pkg.sv]
// types, codes and defaults of the block cache writeback unit
`timescale 1ns / 1ps
package bcfw_pkg;

  localparam int CAPACITY_DEF    = 32;
  localparam int DEVICE_BITS_DEF = 8;
  localparam int BLOCK_BITS_DEF  = 32;

  localparam int TYPE_W = 3;
  localparam int DEV_W  = 8;
  localparam int BLK_W  = 32;
  localparam int SLOT_W = 5;
  localparam int STAT_W = 32;
  localparam int CFG_W  = 6;
  localparam int ACT_W  = 2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 208;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 6'd32;

  localparam logic [TYPE_W-1:0] REQ_READ      = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE     = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_FLUSH_BLK = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_FLUSH_DEV = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_FLUSH_ALL = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_FILL_FAIL = 3'd5;

  localparam logic [ACT_W-1:0] ACT_DONE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FILL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WB   = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic              last;
    logic [STAT_W-1:0] rd_hit_cnt;
    logic [STAT_W-1:0] rd_miss_cnt;
    logic [STAT_W-1:0] wr_hit_cnt;
    logic [STAT_W-1:0] wr_miss_cnt;
    logic [STAT_W-1:0] writebacks;
  } out_item_t;

endpackage

[hw/rtl/block_cache_fifo_writeback_unit.sv]
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser req_type, tdata device_id, block_number
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser action, tlast last, tdata the rest
// cfg       in   cfg_we_i                     cfg_wdata_i max_entries
// one request at a time, accepted in an idle cycle; a lookup or flush walks the age ring,
// per entry visited an order ram read, a tag ram read, a compare; an eviction runs a limit
// test, order read, tag read and check, an insert follows its limit test, a read miss adds
// a fill request step, a fill-failed shift an order read and write per older entry moved,
// then a done step. results leave through a one-entry output register; a full register
// stalls the walk in place. reset clears valid/dirty bits, counts and counters at once.
`timescale 1ns / 1ps
`include "block_cache_fifo_writeback_unit_macros.svh"
module block_cache_fifo_writeback_unit #(
  parameter int CAPACITY    = bcfw_pkg::CAPACITY_DEF,
  parameter int DEVICE_BITS = bcfw_pkg::DEVICE_BITS_DEF,
  parameter int BLOCK_BITS  = bcfw_pkg::BLOCK_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bcfw_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // device_id, block_number
  input  logic [bcfw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic [bcfw_pkg::TYPE_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // hit, slot, out_device, out_block, rd_hit_cnt, rd_miss_cnt, wr_hit_cnt,
  // wr_miss_cnt, writebacks
  output logic [bcfw_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // action
  output logic [bcfw_pkg::ACT_W-1:0]        m_axis_tuser,
  output logic                              m_axis_tlast
);
  import bcfw_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = DEVICE_BITS + BLOCK_BITS;
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [SW-1:0] SLOT_MAX = SW'(CAPACITY - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_W_ORD  = 4'd1;
  localparam logic [3:0] ST_W_TAG  = 4'd2;
  localparam logic [3:0] ST_W_CHK  = 4'd3;
  localparam logic [3:0] ST_EV_TST = 4'd4;
  localparam logic [3:0] ST_EV_ORD = 4'd5;
  localparam logic [3:0] ST_EV_TAG = 4'd6;
  localparam logic [3:0] ST_EV_CHK = 4'd7;
  localparam logic [3:0] ST_INS    = 4'd8;
  localparam logic [3:0] ST_FILL   = 4'd9;
  localparam logic [3:0] ST_SH_RD  = 4'd10;
  localparam logic [3:0] ST_SH_WR  = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0]             state_q, state_d;
  logic [TYPE_W-1:0]      type_q, type_d;
  logic [DEVICE_BITS-1:0] dev_q, dev_d;
  logic [BLOCK_BITS-1:0]  blk_q, blk_d;
  logic [CAPACITY-1:0]    valid_q, valid_d;
  logic [CAPACITY-1:0]    dirty_q, dirty_d;
  logic [CW-1:0]          count_q, count_d;
  logic [SW-1:0]          head_q, head_d;
  logic [CW-1:0]          r_q, r_d;
  logic [SW-1:0]          slot_q, slot_d;
  logic [SW-1:0]          e_q, e_d;
  logic                   hit_q, hit_d;
  logic [STAT_W-1:0]      rh_q, rh_d, rm_q, rm_d, wh_q, wh_d, wm_q, wm_d, wb_q, wb_d;
  logic [CFG_W-1:0]       max_q;

  logic [CW-1:0]          lim;
  logic [SW-1:0]          free_slot;
  logic                   out_free;
  logic                   emit_v;
  out_item_t              emit_item;

  logic                   ord_we;
  logic [SW-1:0]          ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic                   tag_we;
  logic [TW-1:0]          tag_wdata, tag_rdata;

  logic                   hitm, devm, last_r, rw_req;

  // ring position of an age rank
  function automatic logic [SW-1:0] pos_f(input logic [SW-1:0] hd, input logic [CW-1:0] rk);
    logic [SW:0] sum;
    sum = {1'b0, hd} + (SW+1)'(rk);
    if (sum >= (SW+1)'(CAPACITY)) begin
      sum = sum - (SW+1)'(CAPACITY);
    end
    return sum[SW-1:0];
  endfunction

  always_comb begin
    if (max_q == '0) begin
      lim = CW'(1);
    end else if ({1'b0, max_q} > 7'(CAPACITY)) begin
      lim = CAP_C;
    end else begin
      lim = CW'(max_q);
    end
  end

  always_comb begin
    free_slot = SLOT_MAX;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  always_comb begin
    case (state_q)
      ST_EV_ORD, ST_EV_TAG, ST_EV_CHK: ord_raddr = pos_f(head_q, count_q - CW'(1));
      ST_SH_RD:                         ord_raddr = pos_f(head_q, r_q + CW'(1));
      default:                          ord_raddr = pos_f(head_q, r_q);
    endcase
  end

  bcfw_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  bcfw_ram #(.WIDTH(TW), .DEPTH(CAPACITY)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (free_slot),
    .wdata_i (tag_wdata),
    .raddr_i (ord_rdata),
    .rdata_o (tag_rdata)
  );

  assign tag_wdata = {blk_q, dev_q};
  assign hitm      = valid_q[slot_q] && (tag_rdata == {blk_q, dev_q});
  assign devm      = tag_rdata[DEVICE_BITS-1:0] == dev_q;
  assign last_r    = (r_q + CW'(1)) == count_q;
  assign rw_req    = (type_q == REQ_READ) || (type_q == REQ_WRITE);
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    type_d  = type_q;
    dev_d   = dev_q;
    blk_d   = blk_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    count_d = count_q;
    head_d  = head_q;
    r_d     = r_q;
    slot_d  = slot_q;
    e_d     = e_q;
    hit_d   = hit_q;
    rh_d    = rh_q;
    rm_d    = rm_q;
    wh_d    = wh_q;
    wm_d    = wm_q;
    wb_d    = wb_q;
    ord_we    = 1'b0;
    ord_waddr = pos_f(head_q, r_q);
    ord_wdata = ord_rdata;
    tag_we    = 1'b0;
    emit_v    = 1'b0;
    emit_item = '{action: ACT_DONE, hit: 1'b0, slot: '0, dev: DEV_W'(dev_q),
                  blk: BLK_W'(blk_q), last: 1'b0, rd_hit_cnt: rh_q, rd_miss_cnt: rm_q,
                  wr_hit_cnt: wh_q, wr_miss_cnt: wm_q, writebacks: wb_q};

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          type_d = s_axis_tuser;
          dev_d  = s_axis_tdata[DEVICE_BITS-1:0];
          blk_d  = s_axis_tdata[DEV_W +: BLOCK_BITS];
          r_d    = '0;
          hit_d  = 1'b0;
          e_d    = '0;
          if (s_axis_tuser inside {REQ_READ, REQ_WRITE, REQ_FLUSH_BLK, REQ_FILL_FAIL,
                                   REQ_FLUSH_DEV, REQ_FLUSH_ALL}) begin
            if (count_q != '0) begin
              state_d = ST_W_ORD;
            end else if (s_axis_tuser == REQ_READ) begin
              rm_d    = rm_q + 1'b1;
              state_d = ST_EV_TST;
            end else if (s_axis_tuser == REQ_WRITE) begin
              wm_d    = wm_q + 1'b1;
              state_d = ST_EV_TST;
            end else begin
              state_d = ST_DONE;
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_W_ORD: state_d = ST_W_TAG;
      ST_W_TAG: begin
        slot_d  = ord_rdata;
        state_d = ST_W_CHK;
      end
      ST_W_CHK: begin
        case (type_q)
          REQ_READ, REQ_WRITE: begin
            if (hitm || last_r) begin
              hit_d = hitm;
              e_d   = slot_q;
              if (type_q == REQ_READ) begin
                if (hitm) rh_d = rh_q + 1'b1;
                else      rm_d = rm_q + 1'b1;
              end else begin
                if (hitm) wh_d = wh_q + 1'b1;
                else      wm_d = wm_q + 1'b1;
              end
              state_d = ST_EV_TST;
            end else begin
              r_d     = r_q + CW'(1);
              state_d = ST_W_ORD;
            end
          end
          REQ_FLUSH_BLK: begin
            if (hitm) begin
              if (!dirty_q[slot_q]) begin
                state_d = ST_DONE;
              end else if (out_free) begin
                emit_v = 1'b1;
                emit_item.action     = ACT_WB;
                emit_item.slot       = SLOT_W'(slot_q);
                emit_item.dev        = DEV_W'(tag_rdata[DEVICE_BITS-1:0]);
                emit_item.blk        = BLK_W'(tag_rdata[TW-1:DEVICE_BITS]);
                emit_item.writebacks = wb_q + 1'b1;
                dirty_d[slot_q] = 1'b0;
                wb_d    = wb_q + 1'b1;
                state_d = ST_DONE;
              end
            end else if (last_r) begin
              state_d = ST_DONE;
            end else begin
              r_d     = r_q + CW'(1);
              state_d = ST_W_ORD;
            end
          end
          REQ_FLUSH_DEV, REQ_FLUSH_ALL: begin
            if (valid_q[slot_q] && dirty_q[slot_q] && (type_q == REQ_FLUSH_ALL || devm)) begin
              if (out_free) begin
                emit_v = 1'b1;
                emit_item.action     = ACT_WB;
                emit_item.slot       = SLOT_W'(slot_q);
                emit_item.dev        = DEV_W'(tag_rdata[DEVICE_BITS-1:0]);
                emit_item.blk        = BLK_W'(tag_rdata[TW-1:DEVICE_BITS]);
                emit_item.writebacks = wb_q + 1'b1;
                dirty_d[slot_q] = 1'b0;
                wb_d    = wb_q + 1'b1;
                r_d     = r_q + CW'(1);
                state_d = last_r ? ST_DONE : ST_W_ORD;
              end
            end else begin
              r_d     = r_q + CW'(1);
              state_d = last_r ? ST_DONE : ST_W_ORD;
            end
          end
          REQ_FILL_FAIL: begin
            if (hitm) begin
              valid_d[slot_q] = 1'b0;
              dirty_d[slot_q] = 1'b0;
              count_d = count_q - CW'(1);
              // older entries after this rank close the gap
              state_d = last_r ? ST_DONE : ST_SH_RD;
            end else if (last_r) begin
              state_d = ST_DONE;
            end else begin
              r_d     = r_q + CW'(1);
              state_d = ST_W_ORD;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_EV_TST: begin
        if (hit_q ? (count_q > lim) : ((count_q >= lim) && (count_q != '0))) begin
          state_d = ST_EV_ORD;
        end else begin
          state_d = hit_q ? ST_DONE : ST_INS;
        end
      end
      ST_EV_ORD: state_d = ST_EV_TAG;
      ST_EV_TAG: begin
        slot_d  = ord_rdata;
        state_d = ST_EV_CHK;
      end
      ST_EV_CHK: begin
        if (!dirty_q[slot_q] || out_free) begin
          if (dirty_q[slot_q]) begin
            emit_v = 1'b1;
            emit_item.action     = ACT_WB;
            emit_item.slot       = SLOT_W'(slot_q);
            emit_item.dev        = DEV_W'(tag_rdata[DEVICE_BITS-1:0]);
            emit_item.blk        = BLK_W'(tag_rdata[TW-1:DEVICE_BITS]);
            emit_item.writebacks = wb_q + 1'b1;
            wb_d = wb_q + 1'b1;
          end
          dirty_d[slot_q] = 1'b0;
          valid_d[slot_q] = 1'b0;
          count_d = count_q - CW'(1);
          state_d = ST_EV_TST;
        end
      end
      ST_INS: begin
        head_d    = (head_q == '0) ? SLOT_MAX : head_q - SW'(1);
        ord_we    = 1'b1;
        ord_waddr = head_d;
        ord_wdata = free_slot;
        tag_we    = 1'b1;
        e_d       = free_slot;
        valid_d[free_slot] = 1'b1;
        dirty_d[free_slot] = 1'b0;
        count_d   = count_q + CW'(1);
        state_d   = (type_q == REQ_READ) ? ST_FILL : ST_DONE;
      end
      ST_FILL: begin
        if (out_free) begin
          emit_v = 1'b1;
          emit_item.action = ACT_FILL;
          emit_item.slot   = SLOT_W'(e_q);
          state_d = ST_DONE;
        end
      end
      ST_SH_RD: state_d = ST_SH_WR;
      ST_SH_WR: begin
        ord_we    = 1'b1;
        ord_waddr = pos_f(head_q, r_q);
        ord_wdata = ord_rdata;
        r_d       = r_q + CW'(1);
        // count already lowered: stop once the new oldest rank is filled
        state_d   = (({1'b0, r_q} + (CW+1)'(2)) <= {1'b0, count_q}) ? ST_SH_RD : ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          emit_v = 1'b1;
          emit_item.action = ACT_DONE;
          emit_item.hit    = hit_q;
          emit_item.slot   = rw_req ? SLOT_W'(e_q) : '0;
          emit_item.last   = 1'b1;
          if (type_q == REQ_WRITE) begin
            dirty_d[e_q] = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      dirty_q <= '0;
      count_q <= '0;
      head_q  <= '0;
      r_q     <= '0;
      hit_q   <= 1'b0;
      rh_q    <= '0;
      rm_q    <= '0;
      wh_q    <= '0;
      wm_q    <= '0;
      wb_q    <= '0;
      max_q   <= MAX_ENTRIES_RST;
      type_q  <= REQ_READ;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      count_q <= count_d;
      head_q  <= head_d;
      r_q     <= r_d;
      hit_q   <= hit_d;
      rh_q    <= rh_d;
      rm_q    <= rm_d;
      wh_q    <= wh_d;
      wm_q    <= wm_d;
      wb_q    <= wb_d;
      type_q  <= type_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dev_q  <= dev_d;
    blk_q  <= blk_d;
    slot_q <= slot_d;
    e_q    <= e_d;
  end

  bcfw_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (emit_v),
    .item_i        (emit_item),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `BCFW_ASSERT(a_count_matches_valid, $countones(valid_q) == int'(count_q), "count off")
  `BCFW_ASSERT(a_insert_into_free, (state_q != ST_INS) || !valid_q[free_slot], "live insert")
  `BCFW_ASSERT_NEXT(a_last_ends_request, emit_v && emit_item.last, state_q == ST_IDLE, "no idle")

endmodule

[hw/rtl/bcfw_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module bcfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bcfw_out_reg.sv]
// result output register feeding the master stream
`timescale 1ns / 1ps
module bcfw_out_reg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  bcfw_pkg::out_item_t                   item_i,
  output logic                                  free_o,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // hit, slot, out_device, out_block, rd_hit_cnt, rd_miss_cnt, wr_hit_cnt,
  // wr_miss_cnt, writebacks
  output logic [bcfw_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // action
  output logic [bcfw_pkg::ACT_W-1:0]            m_axis_tuser,
  output logic                                  m_axis_tlast
);
  import bcfw_pkg::*;

  logic      vld_q, vld_d;
  out_item_t item_q;

  assign free_o = !vld_q || m_axis_tready;

  always_comb begin
    vld_d = vld_q;
    if (m_axis_tready) begin
      vld_d = 1'b0;
    end
    if (push_i) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = item_q.action;
  assign m_axis_tlast  = item_q.last;
  assign m_axis_tdata  = {2'b00, item_q.writebacks, item_q.wr_miss_cnt, item_q.wr_hit_cnt,
                          item_q.rd_miss_cnt, item_q.rd_hit_cnt, item_q.blk, item_q.dev,
                          item_q.slot, item_q.hit};

endmodule

[bench/testbench.sv]
// self-checking bench for the block cache writeback unit: random requests, stalls, limits
`timescale 1ns / 1ps
module testbench;
  import bcfw_pkg::*;

  localparam int NSLOT = CAPACITY_DEF;
  localparam int WATCH_LIMIT = 20000;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_A = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_B = 3'd7;

  typedef struct {
    logic [TYPE_W-1:0] kind;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
  } cache_req_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [TYPE_W-1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [ACT_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  block_cache_fifo_writeback_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // cache shadow state
  logic             sh_valid [NSLOT];
  logic [DEV_W-1:0] sh_dev   [NSLOT];
  logic [BLK_W-1:0] sh_blk   [NSLOT];
  logic             sh_dirty [NSLOT];
  int unsigned      sh_rank  [NSLOT];
  int unsigned      sh_count;
  logic [STAT_W-1:0] st_rd_hit, st_rd_miss, st_wr_hit, st_wr_miss, st_wb;
  logic [CFG_W-1:0] max_entries;

  cache_req_t pending_reqs[$];
  out_item_t  expected_results[$];
  int errors, reqs_sent, results_seen;
  int burst_left, gap_left, stall_left, watch_cnt;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
  endtask

  function automatic void push_result(logic [ACT_W-1:0] act, logic hit, int slot,
                                      logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                                      logic last);
    out_item_t r;
    r.action = act; r.hit = hit; r.slot = slot[SLOT_W-1:0]; r.dev = dev; r.blk = blk;
    r.last = last; r.rd_hit_cnt = st_rd_hit; r.rd_miss_cnt = st_rd_miss;
    r.wr_hit_cnt = st_wr_hit; r.wr_miss_cnt = st_wr_miss; r.writebacks = st_wb;
    expected_results.push_back(r);
  endfunction

  function automatic void write_back_slot(int i);
    if (sh_dirty[i]) begin
      sh_dirty[i] = 0;
      st_wb++;
      push_result(ACT_WB, 0, i, sh_dev[i], sh_blk[i], 0);
    end
  endfunction

  function automatic void evict_oldest();
    for (int i = 0; i < NSLOT; i++) begin
      if (sh_valid[i] && sh_rank[i] == sh_count - 1) begin
        write_back_slot(i);
        sh_valid[i] = 0;
        sh_count--;
        return;
      end
    end
    sh_count = 0;
  endfunction

  function automatic int lookup(logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk);
    for (int i = 0; i < NSLOT; i++)
      if (sh_valid[i] && sh_dev[i] == dev && sh_blk[i] == blk) return i;
    return -1;
  endfunction

  function automatic void predict_request(cache_req_t q);
    int unsigned lim;
    int e, r;
    logic hit;
    lim = (max_entries == 0) ? 1 : (max_entries > NSLOT) ? NSLOT : max_entries;
    if (q.kind == REQ_READ || q.kind == REQ_WRITE) begin
      e = lookup(q.dev, q.blk);
      hit = (e >= 0);
      if (q.kind == REQ_READ) begin
        if (hit) st_rd_hit++; else st_rd_miss++;
      end else begin
        if (hit) st_wr_hit++; else st_wr_miss++;
      end
      if (hit) begin
        while (sh_count > lim) evict_oldest();
      end else begin
        while (sh_count + 1 > lim && sh_count > 0) evict_oldest();
        for (int i = 0; i < NSLOT; i++) if (sh_valid[i]) sh_rank[i]++;
        for (e = 0; e < NSLOT - 1 && sh_valid[e]; e++) ;
        sh_valid[e] = 1; sh_dev[e] = q.dev; sh_blk[e] = q.blk;
        sh_dirty[e] = 0; sh_rank[e] = 0; sh_count++;
        if (q.kind == REQ_READ) push_result(ACT_FILL, 0, e, q.dev, q.blk, 0);
      end
      if (q.kind == REQ_WRITE) sh_dirty[e] = 1;
      push_result(ACT_DONE, hit, e, q.dev, q.blk, 1);
      return;
    end
    if (q.kind == REQ_FLUSH_BLK) begin
      e = lookup(q.dev, q.blk);
      if (e >= 0) write_back_slot(e);
    end else if (q.kind == REQ_FLUSH_DEV || q.kind == REQ_FLUSH_ALL) begin
      // newest first
      for (int unsigned rk = 0; rk < sh_count; rk++)
        for (int k = 0; k < NSLOT; k++)
          if (sh_valid[k] && sh_rank[k] == rk &&
              (q.kind == REQ_FLUSH_ALL || sh_dev[k] == q.dev))
            write_back_slot(k);
    end else if (q.kind == REQ_FILL_FAIL) begin
      e = lookup(q.dev, q.blk);
      if (e >= 0) begin
        r = sh_rank[e];
        sh_valid[e] = 0; sh_dirty[e] = 0; sh_count--;
        for (int k = 0; k < NSLOT; k++)
          if (sh_valid[k] && sh_rank[k] > r) sh_rank[k]--;
      end
    end
    push_result(ACT_DONE, 0, 0, q.dev, q.blk, 1);
  endfunction

  // request driver, bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(pending_reqs.pop_front());
        reqs_sent++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the request
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 0;
      end else if (pending_reqs.size() > 0) begin
        s_axis_tvalid <= 1;
        s_axis_tuser  <= pending_reqs[0].kind;
        s_axis_tdata  <= {pending_reqs[0].blk, pending_reqs[0].dev};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // result monitor with its own stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      m_axis_tready <= 0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("unexpected result %0d", results_seen);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser != want.action) report("action", m_axis_tuser, want.action);
          if (m_axis_tlast != want.last) report("last", m_axis_tlast, want.last);
          if (m_axis_tdata[0] != want.hit) report("hit", m_axis_tdata[0], want.hit);
          if (m_axis_tdata[5:1] != want.slot) report("slot", m_axis_tdata[5:1], want.slot);
          if (m_axis_tdata[13:6] != want.dev) report("device", m_axis_tdata[13:6], want.dev);
          if (m_axis_tdata[45:14] != want.blk) report("block", m_axis_tdata[45:14], want.blk);
          if (m_axis_tdata[77:46] != want.rd_hit_cnt)
            report("rd_hit_cnt", m_axis_tdata[77:46], want.rd_hit_cnt);
          if (m_axis_tdata[109:78] != want.rd_miss_cnt)
            report("rd_miss_cnt", m_axis_tdata[109:78], want.rd_miss_cnt);
          if (m_axis_tdata[141:110] != want.wr_hit_cnt)
            report("wr_hit_cnt", m_axis_tdata[141:110], want.wr_hit_cnt);
          if (m_axis_tdata[173:142] != want.wr_miss_cnt)
            report("wr_miss_cnt", m_axis_tdata[173:142], want.wr_miss_cnt);
          if (m_axis_tdata[205:174] != want.writebacks)
            report("writebacks", m_axis_tdata[205:174], want.writebacks);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 0;
      end else if ($urandom_range(0, 9) < 2) begin
        stall_left <= $urandom_range(1, 8);
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // watchdog on request and result traffic
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      watch_cnt <= 0;
    else if (watch_cnt >= WATCH_LIMIT) begin
      $display("timeout after %0d idle cycles", watch_cnt);
      $display("status: fail");
      $finish;
    end else
      watch_cnt <= watch_cnt + 1;
  end

  cache_req_t addr_pool[48];

  task automatic add_req(logic [TYPE_W-1:0] kind, logic [DEV_W-1:0] dev,
                         logic [BLK_W-1:0] blk);
    cache_req_t q;
    q.kind = kind; q.dev = dev; q.blk = blk;
    pending_reqs.push_back(q);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    max_entries = v;
  endtask

  task automatic add_random(int n);
    int p, sel;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 47);
      sel = $urandom_range(0, 99);
      if (sel < 38) add_req(REQ_READ, addr_pool[p].dev, addr_pool[p].blk);
      else if (sel < 70) add_req(REQ_WRITE, addr_pool[p].dev, addr_pool[p].blk);
      else if (sel < 80) add_req(REQ_FLUSH_BLK, addr_pool[p].dev, addr_pool[p].blk);
      else if (sel < 85) add_req(REQ_FLUSH_DEV, addr_pool[p].dev, $urandom);
      else if (sel < 88) add_req(REQ_FLUSH_ALL, DEV_W'($urandom), $urandom);
      else if (sel < 95) add_req(REQ_FILL_FAIL, addr_pool[p].dev, addr_pool[p].blk);
      else if (sel < 97)
        add_req(TYPE_W'($urandom_range(REQ_UNUSED_A, REQ_UNUSED_B)), DEV_W'($urandom),
                $urandom);
      else add_req(TYPE_W'($urandom_range(REQ_READ, REQ_WRITE)), DEV_W'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] limits[8];
    limits = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd4, 6'd33, 6'd8, 6'd31};
    cfg_we_i = 0; cfg_wdata_i = MAX_ENTRIES_RST;
    errors = 0; reqs_sent = 0; results_seen = 0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 0; sh_dirty[i] = 0; sh_rank[i] = 0; sh_dev[i] = 0; sh_blk[i] = 0;
    end
    sh_count = 0; max_entries = MAX_ENTRIES_RST;
    st_rd_hit = 0; st_rd_miss = 0; st_wr_hit = 0; st_wr_miss = 0; st_wb = 0;
    // few devices so flush device finds matches, but full-range values as well
    for (int i = 0; i < 48; i++) begin
      addr_pool[i].kind = REQ_READ;
      addr_pool[i].dev = (i < 32) ? DEV_W'($urandom_range(0, 3)) : DEV_W'($urandom);
      addr_pool[i].blk = (i < 16) ? BLK_W'($urandom_range(0, 7)) : BLK_W'($urandom);
    end
    rst_ni = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;

    // directed: extremes, every request kind, corner cases
    add_req(REQ_FLUSH_BLK, 8'h00, 32'h0);
    add_req(REQ_FILL_FAIL, 8'hff, 32'hffffffff);
    add_req(REQ_READ, 8'h00, 32'h0);
    add_req(REQ_READ, 8'h00, 32'h0);
    add_req(REQ_WRITE, 8'hff, 32'hffffffff);
    add_req(REQ_WRITE, 8'hff, 32'hffffffff);
    add_req(REQ_WRITE, 8'h00, 32'h0);
    add_req(REQ_READ, 8'h5a, 32'ha5a5a5a5);
    add_req(REQ_FLUSH_BLK, 8'hff, 32'hffffffff);
    add_req(REQ_FLUSH_BLK, 8'hff, 32'hffffffff);
    add_req(REQ_WRITE, 8'h5a, 32'h12345678);
    add_req(REQ_FLUSH_DEV, 8'h5a, 32'h0);
    add_req(REQ_WRITE, 8'h01, 32'h1);
    add_req(REQ_FILL_FAIL, 8'h00, 32'h0);
    add_req(REQ_READ, 8'h02, 32'h2);
    add_req(REQ_FLUSH_ALL, 8'h00, 32'h0);
    add_req(REQ_UNUSED_A, 8'haa, 32'h55555555);
    add_req(REQ_UNUSED_B, 8'h55, 32'haaaaaaaa);
    wait_idle();
    // lowered limit applies at next read or write, with dirty entries to evict
    for (int i = 0; i < 6; i++) add_req(REQ_WRITE, 8'h10, i);
    wait_idle();
    set_limit(6'd2);
    add_req(REQ_FLUSH_BLK, 8'h10, 32'h0);
    add_req(REQ_READ, 8'h10, 32'h5);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      set_limit(limits[ph]);
      add_random(32);
      wait_idle();
    end
    add_req(REQ_FLUSH_ALL, 8'h00, 32'h0);
    wait_idle();

    $display("sent %0d requests over %0d limit settings, checked %0d results",
             reqs_sent, 10, results_seen);
    $display("stats: rd hit %0d miss %0d, wr hit %0d miss %0d, writebacks %0d",
             st_rd_hit, st_rd_miss, st_wr_hit, st_wr_miss, st_wb);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bcfw_pkg.sv
hw/rtl/bcfw_ram.sv
hw/rtl/bcfw_out_reg.sv
hw/rtl/block_cache_fifo_writeback_unit.sv
bench/testbench.sv
